FILE: hw/rtl/bigr_pkg.sv
// bigr_pkg: shared types, register codes and reset values for the binary
// interior grid reduce unit. No dependencies.
package bigr_pkg;

  localparam int DefMaxWidth = 1024;
  localparam int XW          = 10;
  localparam int YW          = 12;
  localparam int WREGW       = 11;
  localparam int HREGW       = 13;
  localparam int SREGW       = 16;
  localparam int HeightMax   = 4096;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;

  localparam logic [WREGW-1:0] RST_WIDTH   = 11'd1024;
  localparam logic [HREGW-1:0] RST_HEIGHT  = 13'd1024;
  localparam logic [SREGW-1:0] RST_SPACING = 16'd1000;

  typedef struct packed {
    logic [WREGW-1:0] image_width;
    logic [HREGW-1:0] image_height;
    logic [SREGW-1:0] grid_spacing;
  } cfg_t;

  // one pixel in flight between the line store read and the write back
  typedef struct packed {
    logic          pix;
    logic          emit;
    logic          grid;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } item_t;

endpackage

FILE: hw/rtl/bigr_line_mem.sv
// bigr_line_mem: line store holding rows y-2 and y-1 for each column, one
// 2-bit entry per column, registered read. Depends on nothing.
module bigr_line_mem #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  output logic [1:0]                   rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [1:0]                   wr_data_i
);

  // bit 1 row y-2, bit 0 row y-1
  logic [1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: hw/rtl/bigr_scan.sv
// bigr_scan: raster position and grid phase counters, clamps of the
// configuration, and the per-pixel item register. Uses bigr_pkg.
module bigr_scan #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bigr_pkg::cfg_t               cfg_i,
  input  logic                         accept_i,
  input  logic                         pixel_set_i,
  input  logic                         frame_start_i,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr_o,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr_o,
  output bigr_pkg::item_t              item_o
);
  import bigr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > WREGW) ? CW + 1 : WREGW;
  localparam int PW = SREGW + 1;

  logic [CW-1:0]    col_q, col_d, c0, c1;
  logic [YW-1:0]    row_q, row_d, r0, r1;
  logic [SREGW-1:0] cph_q, cph_d, cp0;
  logic [SREGW-1:0] rph_q, rph_d, rp0;
  logic [WW-1:0]    w_raw, w_eff, c_ext, xm1;
  logic [HREGW-1:0] h_eff, r_ext;
  logic [SREGW-1:0] s_eff;
  logic             s_one, cgrid, rgrid;
  logic [PW-1:0]    cp_inc, rp_inc;
  logic [SREGW-1:0] cp_next, rp_next;
  item_t            item_q, item_d;
  logic [CW-1:0]    wr_addr_q;

  always_comb begin
    w_raw = WW'(cfg_i.image_width);
    priority if (w_raw < WW'(3))                 w_eff = WW'(3);
    else if (w_raw > WW'(MAX_WIDTH))             w_eff = WW'(MAX_WIDTH);
    else                                         w_eff = w_raw;

    priority if (cfg_i.image_height < HREGW'(3))         h_eff = HREGW'(3);
    else if (cfg_i.image_height > HREGW'(HeightMax))     h_eff = HREGW'(HeightMax);
    else                                                 h_eff = cfg_i.image_height;

    s_eff = (cfg_i.grid_spacing == '0) ? SREGW'(1) : cfg_i.grid_spacing;
    s_one = (s_eff == SREGW'(1));
  end

  always_comb begin
    c0  = frame_start_i ? '0 : col_q;
    r0  = frame_start_i ? '0 : row_q;
    cp0 = frame_start_i ? '0 : cph_q;
    rp0 = frame_start_i ? '0 : rph_q;

    // counters past a shrunk limit wrap at once, phases keep counting
    c1 = (WW'(c0) >= w_eff) ? '0 : c0;
    r1 = (HREGW'(r0) >= h_eff) ? '0 : r0;

    c_ext = WW'(c1);
    r_ext = HREGW'(r1);
    xm1   = c_ext - WW'(1);

    // previous phase is zero when the phase is one, or zero with pitch one
    cgrid = (cp0 == SREGW'(1)) || ((cp0 == '0) && s_one);
    rgrid = (rp0 == SREGW'(1)) || ((rp0 == '0) && s_one);

    cp_inc  = PW'(cp0) + PW'(1);
    rp_inc  = PW'(rp0) + PW'(1);
    cp_next = (cp_inc >= PW'(s_eff)) ? '0 : cp_inc[SREGW-1:0];
    rp_next = (rp_inc >= PW'(s_eff)) ? '0 : rp_inc[SREGW-1:0];

    item_d.pix  = pixel_set_i;
    item_d.emit = (c_ext >= WW'(2)) && (r_ext >= HREGW'(2));
    item_d.grid = cgrid && rgrid;
    item_d.x    = xm1[XW-1:0];
    item_d.y    = r1 - YW'(1);

    if (c_ext + WW'(1) >= w_eff) begin
      col_d = '0;
      cph_d = '0;
      if (r_ext + HREGW'(1) >= h_eff) begin
        row_d = '0;
        rph_d = '0;
      end else begin
        row_d = r1 + YW'(1);
        rph_d = rp_next;
      end
    end else begin
      col_d = c1 + CW'(1);
      cph_d = cp_next;
      row_d = r1;
      rph_d = rp0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q    <= item_d;
      wr_addr_q <= c1;
    end
  end

  assign rd_addr_o = c1;
  assign wr_addr_o = wr_addr_q;
  assign item_o    = item_q;

endmodule

FILE: hw/rtl/bigr_win.sv
// bigr_win: 3x3 neighbour window fed from the line store read data, and the
// keep decision for the window center. Uses bigr_pkg.
module bigr_win (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [1:0]      rd_data_i,
  input  bigr_pkg::item_t item_i,
  output logic            keep_o
);
  import bigr_pkg::*;

  logic [8:0] win_q, win_d;
  logic       ctr, lft, rgt, abv, blw;

  // newest column in the low bits: bit 2 row y-2, bit 1 row y-1, bit 0 row y
  assign win_d = {win_q[5:0], rd_data_i[1], rd_data_i[0], item_i.pix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (adv_i) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    ctr = win_d[4];
    lft = win_d[7];
    rgt = win_d[1];
    abv = win_d[5];
    blw = win_d[3];
    if (!ctr) begin
      keep_o = 1'b0;
    end else if (lft && rgt && abv && blw) begin
      keep_o = item_i.grid;
    end else begin
      keep_o = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/binary_interior_grid_reduce_unit.sv
// binary_interior_grid_reduce_unit: top level of the binary interior grid
// reduce block. Uses bigr_pkg, bigr_scan, bigr_line_mem and bigr_win.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  pixel_set_i, frame_start_i
//   out      output     out_valid_o/out_stall_i out_x_o, out_y_o, keep_o
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata
//
// one pixel per cycle unless stalled; out_valid_o rises once the request
// completing the pixel's neighbourhood passes the item and output registers;
// the line store is read as a request is taken and written back as its pixel
// finishes; a read of the column being written back takes the write data
// reset clears counters, window and valid flags; the line store is not cleared
// an output stall holds a pending pixel that gives a result and stalls input
module binary_interior_grid_reduce_unit #(
  parameter int MAX_WIDTH = bigr_pkg::DefMaxWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   pixel_set_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [bigr_pkg::XW-1:0] out_x_o,
  output logic [bigr_pkg::YW-1:0] out_y_o,
  output logic                   keep_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import bigr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  cfg_t          cfg_q;
  logic          cfg_wr;
  logic          accept, s1_q, s1_adv;
  logic [CW-1:0] rd_addr, wr_addr;
  logic [1:0]    rd_data;
  logic [1:0]    rd_eff, wr_data, fwd_data_q;
  logic          fwd_q;
  item_t         item;
  logic          keep;
  logic          out_valid_q;
  logic [XW-1:0] out_x_q;
  logic [YW-1:0] out_y_q;
  logic          keep_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= RST_WIDTH;
      cfg_q.image_height <= RST_HEIGHT;
      cfg_q.grid_spacing <= RST_SPACING;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:   cfg_q.image_width  <= pwdata[WREGW-1:0];
        REG_HEIGHT:  cfg_q.image_height <= pwdata[HREGW-1:0];
        REG_SPACING: cfg_q.grid_spacing <= pwdata[SREGW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:   prdata = 32'(cfg_q.image_width);
      REG_HEIGHT:  prdata = 32'(cfg_q.image_height);
      REG_SPACING: prdata = 32'(cfg_q.grid_spacing);
      default:     prdata = '0;
    endcase
  end

  // pending pixel finishes when it gives no result or the output slot frees
  assign s1_adv     = s1_q && (!item.emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (accept) begin
      s1_q <= 1'b1;
    end else if (s1_adv) begin
      s1_q <= 1'b0;
    end
  end

  bigr_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .pixel_set_i   (pixel_set_i),
    .frame_start_i (frame_start_i),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .item_o        (item)
  );

  // a frame restart on column 0 right after a column 0 pixel reads the
  // column that is being written back in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= s1_adv && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= wr_data;
    end
  end

  assign rd_eff  = fwd_q ? fwd_data_q : rd_data;
  assign wr_data = {rd_eff[0], item.pix};

  bigr_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  bigr_win u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .rd_data_i (rd_eff),
    .item_i    (item),
    .keep_o    (keep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && item.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && item.emit) begin
      out_x_q <= item.x;
      out_y_q <= item.y;
      keep_q  <= keep;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign keep_o      = keep_q;

endmodule

FILE: hw/rtl/bigr_check.sv
// bigr_check: port-level assertions for the binary interior grid reduce unit,
// bound to the top level. Uses bigr_pkg for field widths.
module bigr_check (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [bigr_pkg::XW-1:0] out_x_o,
  input logic [bigr_pkg::YW-1:0] out_y_o,
  input logic                    keep_o,
  input logic                    pready
);
  import bigr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) &&
    $stable(out_y_o) && $stable(keep_o))
    else $error("stalled result changed");

  // input is only stalled behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // a fresh result traces back through the output and item registers to a taken request
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without request");

  // interior rows only
  a_row_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_y_o != '0)
    else $error("result on border row");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && pready)
    else $error("output valid in reset");

endmodule

bind binary_interior_grid_reduce_unit bigr_check u_bigr_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .keep_o      (keep_o),
  .pready      (pready)
);
